// ===== src/qlsf_pkg.sv =====
// Shared types, constants and the sequencer microcode for the quadratic fit.
// Used by qlsf_alu and quadratic_least_squares_fit; no dependencies.
`timescale 1ns / 1ps

package qlsf_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int X_W         = 12;
   localparam int Y_W         = 16;
   localparam int FRAC_BITS   = 16;
   localparam int CNT_W       = 11;
   localparam int OUT_W       = 48;
   localparam int DW          = 192;            // working width of all sums and products
   localparam int AW          = DW + 2;         // adder width, room for the divide borrow
   localparam int CW          = $clog2(DW);
   localparam int DEPTH       = 20;
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int PC_W        = 7;

   localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_SINGULAR = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      OP_LDX, OP_LDY, OP_LDN, OP_CLR, OP_ADD, OP_SUB, OP_MUL, OP_FIX,
      OP_CHKZ, OP_BRSING, OP_ENDS, OP_DONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] dst;
      logic [SLOT_W-1:0] a;
      logic [SLOT_W-1:0] b;
   } instr_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_req_type;

   typedef struct packed {
      logic          done;
      logic [DW-1:0] result;
   } alu_rsp_type;

   // scratch memory slots
   localparam logic [SLOT_W-1:0] R_X   = 5'd0;
   localparam logic [SLOT_W-1:0] R_Y   = 5'd1;
   localparam logic [SLOT_W-1:0] R_N   = 5'd2;
   localparam logic [SLOT_W-1:0] R_S1  = 5'd3;
   localparam logic [SLOT_W-1:0] R_S2  = 5'd4;
   localparam logic [SLOT_W-1:0] R_S3  = 5'd5;
   localparam logic [SLOT_W-1:0] R_S4  = 5'd6;
   localparam logic [SLOT_W-1:0] R_T0  = 5'd7;
   localparam logic [SLOT_W-1:0] R_T1  = 5'd8;
   localparam logic [SLOT_W-1:0] R_T2  = 5'd9;
   localparam logic [SLOT_W-1:0] R_P   = 5'd10;
   localparam logic [SLOT_W-1:0] R_Q   = 5'd11;
   localparam logic [SLOT_W-1:0] R_C00 = 5'd12;
   localparam logic [SLOT_W-1:0] R_C01 = 5'd13;
   localparam logic [SLOT_W-1:0] R_C02 = 5'd14;
   localparam logic [SLOT_W-1:0] R_P2  = 5'd15;
   localparam logic [SLOT_W-1:0] R_E   = 5'd16;
   localparam logic [SLOT_W-1:0] R_F   = 5'd17;
   localparam logic [SLOT_W-1:0] R_D   = 5'd18;
   localparam logic [SLOT_W-1:0] R_R   = 5'd19;

   // result selects for OP_FIX
   localparam logic [SLOT_W-1:0] OUT_QUAD  = 5'd0;
   localparam logic [SLOT_W-1:0] OUT_LIN   = 5'd1;
   localparam logic [SLOT_W-1:0] OUT_CONST = 5'd2;

   localparam logic [PC_W-1:0] SAMPLE_PC = 7'd0;
   localparam logic [PC_W-1:0] SOLVE_PC  = 7'd15;
   localparam logic [PC_W-1:0] CLEAR_PC  = 7'd61;

   function automatic instr_type mk(op_type op, logic [SLOT_W-1:0] dst,
                                    logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b);
      instr_type i;
      i.op  = op;
      i.dst = dst;
      i.a   = a;
      i.b   = b;
      return i;
   endfunction

   // Microcode. For OP_MUL the bit length of the b operand sets the loop count.
   function automatic instr_type rom_fetch(logic [PC_W-1:0] pc);
      instr_type i;
      case (pc)
         // per sample
         7'd0:  i = mk(OP_LDX, R_X, R_X, R_X);
         7'd1:  i = mk(OP_LDY, R_Y, R_Y, R_Y);
         7'd2:  i = mk(OP_MUL, R_P, R_X, R_X);
         7'd3:  i = mk(OP_ADD, R_S2, R_S2, R_P);
         7'd4:  i = mk(OP_MUL, R_Q, R_P, R_X);
         7'd5:  i = mk(OP_ADD, R_S3, R_S3, R_Q);
         7'd6:  i = mk(OP_MUL, R_Q, R_Q, R_X);
         7'd7:  i = mk(OP_ADD, R_S4, R_S4, R_Q);
         7'd8:  i = mk(OP_ADD, R_S1, R_S1, R_X);
         7'd9:  i = mk(OP_ADD, R_T0, R_T0, R_Y);
         7'd10: i = mk(OP_MUL, R_Q, R_Y, R_X);
         7'd11: i = mk(OP_ADD, R_T1, R_T1, R_Q);
         7'd12: i = mk(OP_MUL, R_Q, R_Q, R_X);
         7'd13: i = mk(OP_ADD, R_T2, R_T2, R_Q);
         7'd14: i = mk(OP_ENDS, R_X, R_X, R_X);
         // solve: cofactors
         7'd15: i = mk(OP_LDN, R_N, R_N, R_N);
         7'd16: i = mk(OP_MUL, R_P, R_S2, R_N);
         7'd17: i = mk(OP_MUL, R_Q, R_S1, R_S1);
         7'd18: i = mk(OP_SUB, R_C00, R_P, R_Q);
         7'd19: i = mk(OP_MUL, R_P, R_S3, R_N);
         7'd20: i = mk(OP_MUL, R_Q, R_S2, R_S1);
         7'd21: i = mk(OP_SUB, R_C01, R_P, R_Q);
         7'd22: i = mk(OP_MUL, R_P, R_S3, R_S1);
         7'd23: i = mk(OP_MUL, R_Q, R_S2, R_S2);
         7'd24: i = mk(OP_SUB, R_C02, R_P, R_Q);
         7'd25: i = mk(OP_MUL, R_P, R_S4, R_S2);
         7'd26: i = mk(OP_MUL, R_Q, R_S3, R_S3);
         7'd27: i = mk(OP_SUB, R_P2, R_P, R_Q);
         7'd28: i = mk(OP_MUL, R_P, R_S4, R_N);
         7'd29: i = mk(OP_MUL, R_Q, R_S2, R_S2);
         7'd30: i = mk(OP_SUB, R_E, R_P, R_Q);
         7'd31: i = mk(OP_MUL, R_P, R_S4, R_S1);
         7'd32: i = mk(OP_MUL, R_Q, R_S2, R_S3);
         7'd33: i = mk(OP_SUB, R_F, R_P, R_Q);
         // determinant and singular checks
         7'd34: i = mk(OP_MUL, R_P, R_C00, R_S4);
         7'd35: i = mk(OP_MUL, R_Q, R_C01, R_S3);
         7'd36: i = mk(OP_SUB, R_D, R_P, R_Q);
         7'd37: i = mk(OP_MUL, R_P, R_C02, R_S2);
         7'd38: i = mk(OP_ADD, R_D, R_D, R_P);
         7'd39: i = mk(OP_CHKZ, R_X, R_S4, R_S4);
         7'd40: i = mk(OP_CHKZ, R_X, R_P2, R_P2);
         7'd41: i = mk(OP_CHKZ, R_X, R_D, R_D);
         7'd42: i = mk(OP_BRSING, R_X, R_X, R_X);
         // a = (t2*C00 - t1*C01 + t0*C02) / d
         7'd43: i = mk(OP_MUL, R_P, R_C00, R_T2);
         7'd44: i = mk(OP_MUL, R_Q, R_C01, R_T1);
         7'd45: i = mk(OP_SUB, R_R, R_P, R_Q);
         7'd46: i = mk(OP_MUL, R_P, R_C02, R_T0);
         7'd47: i = mk(OP_ADD, R_R, R_R, R_P);
         7'd48: i = mk(OP_FIX, OUT_QUAD, R_R, R_D);
         // b = (t1*E - t2*C01 - t0*F) / d
         7'd49: i = mk(OP_MUL, R_P, R_E, R_T1);
         7'd50: i = mk(OP_MUL, R_Q, R_C01, R_T2);
         7'd51: i = mk(OP_SUB, R_R, R_P, R_Q);
         7'd52: i = mk(OP_MUL, R_P, R_F, R_T0);
         7'd53: i = mk(OP_SUB, R_R, R_R, R_P);
         7'd54: i = mk(OP_FIX, OUT_LIN, R_R, R_D);
         // c = (t2*C02 - t1*F + t0*P2) / d
         7'd55: i = mk(OP_MUL, R_P, R_C02, R_T2);
         7'd56: i = mk(OP_MUL, R_Q, R_F, R_T1);
         7'd57: i = mk(OP_SUB, R_R, R_P, R_Q);
         7'd58: i = mk(OP_MUL, R_P, R_P2, R_T0);
         7'd59: i = mk(OP_ADD, R_R, R_R, R_P);
         7'd60: i = mk(OP_FIX, OUT_CONST, R_R, R_D);
         // clear sums
         7'd61: i = mk(OP_CLR, R_S1, R_X, R_X);
         7'd62: i = mk(OP_CLR, R_S2, R_X, R_X);
         7'd63: i = mk(OP_CLR, R_S3, R_X, R_X);
         7'd64: i = mk(OP_CLR, R_S4, R_X, R_X);
         7'd65: i = mk(OP_CLR, R_T0, R_X, R_X);
         7'd66: i = mk(OP_CLR, R_T1, R_X, R_X);
         7'd67: i = mk(OP_CLR, R_T2, R_X, R_X);
         default: i = mk(OP_DONE, R_X, R_X, R_X);
      endcase
      return i;
   endfunction

endpackage

// ===== src/qlsf_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module qlsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/qlsf_alu.sv =====
// Shared arithmetic unit: add, subtract, shift-add multiply and the
// round/saturate restoring divide. Depends on qlsf_pkg.
`timescale 1ns / 1ps

module qlsf_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  qlsf_pkg::alu_req_type      req,
   input  logic [qlsf_pkg::DW-1:0]    opnd_a,
   input  logic [qlsf_pkg::DW-1:0]    opnd_b,
   output qlsf_pkg::alu_rsp_type      rsp
);

   typedef enum logic [2:0] {
      A_IDLE, A_ADD, A_ABSA, A_ABSB, A_MUL, A_FPREP, A_DIV, A_FSAT_SIGN
   } astate_type;

   astate_type                    state_ff;
   qlsf_pkg::op_type              op_ff;
   logic                          neg_ff;
   logic                          sign_ff;
   logic [qlsf_pkg::DW-1:0]       ma_ff;
   logic [qlsf_pkg::DW-1:0]       mb_ff;
   logic [qlsf_pkg::DW:0]         acc_ff;
   logic [qlsf_pkg::DW-1:0]       q_ff;
   logic [qlsf_pkg::CW-1:0]       cnt_ff;
   logic                          done_ff;
   logic [qlsf_pkg::DW-1:0]       result_ff;

   logic [qlsf_pkg::AW-1:0]       add_x;
   logic [qlsf_pkg::AW-1:0]       add_y;
   logic                          add_c;
   logic [qlsf_pkg::AW-1:0]       sum;
   logic [qlsf_pkg::DW:0]         rem_sh;
   logic                          is_sub;
   logic [qlsf_pkg::OUT_W-1:0]    mag;
   logic [qlsf_pkg::OUT_W-1:0]    sat;

   assign rem_sh = {acc_ff[qlsf_pkg::DW-1:0], ma_ff[qlsf_pkg::DW-1]};
   assign is_sub = (op_ff == qlsf_pkg::OP_SUB);

   always_comb begin
      mag = (|q_ff[qlsf_pkg::DW-1:qlsf_pkg::OUT_W]) ? qlsf_pkg::NEG_LIM
                                                   : q_ff[qlsf_pkg::OUT_W-1:0];
      if (!neg_ff && mag > qlsf_pkg::POS_LIM) begin
         sat = qlsf_pkg::POS_LIM;
      end else if (neg_ff && mag > qlsf_pkg::NEG_LIM) begin
         sat = qlsf_pkg::NEG_LIM;
      end else begin
         sat = mag;
      end
   end

   // single shared adder, inputs steered by state
   always_comb begin
      add_x = '0;
      add_y = '0;
      add_c = 1'b0;
      unique case (state_ff)
         A_ADD: begin
            add_x = {2'b00, opnd_a};
            add_y = {2'b00, is_sub ? ~opnd_b : opnd_b};
            add_c = is_sub;
         end
         A_ABSA: begin
            add_x = {2'b00, opnd_a[qlsf_pkg::DW-1] ? ~opnd_a : opnd_a};
            add_c = opnd_a[qlsf_pkg::DW-1];
         end
         A_ABSB: begin
            add_x = {2'b00, opnd_b[qlsf_pkg::DW-1] ? ~opnd_b : opnd_b};
            add_c = opnd_b[qlsf_pkg::DW-1];
         end
         A_MUL: begin
            add_x = {2'b00, acc_ff[qlsf_pkg::DW-1:0]};
            add_y = {2'b00, ma_ff};
         end
         A_FPREP: begin
            add_x = {2'b00, ma_ff << (qlsf_pkg::FRAC_BITS + 1)};
            add_y = {2'b00, mb_ff};
         end
         A_DIV: begin
            add_x = {1'b0, rem_sh};
            add_y = ~{2'b00, mb_ff};
            add_c = 1'b1;
         end
         A_FSAT_SIGN: begin
            // sign_ff low: saturate pass; high: apply sign to acc
            add_x = {2'b00, neg_ff ? ~acc_ff[qlsf_pkg::DW-1:0] : acc_ff[qlsf_pkg::DW-1:0]};
            add_c = neg_ff;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   assign sum = add_x + add_y + {{(qlsf_pkg::AW-1){1'b0}}, add_c};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (req.start) begin
                  op_ff <= req.op;
                  if (req.op == qlsf_pkg::OP_ADD || req.op == qlsf_pkg::OP_SUB) begin
                     state_ff <= A_ADD;
                  end else begin
                     state_ff <= A_ABSA;
                  end
               end
            end
            A_ADD: begin
               result_ff <= sum[qlsf_pkg::DW-1:0];
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            A_ABSA: begin
               ma_ff    <= sum[qlsf_pkg::DW-1:0];
               neg_ff   <= opnd_a[qlsf_pkg::DW-1] ^ opnd_b[qlsf_pkg::DW-1];
               state_ff <= A_ABSB;
            end
            A_ABSB: begin
               mb_ff   <= sum[qlsf_pkg::DW-1:0];
               acc_ff  <= '0;
               q_ff    <= '0;
               sign_ff <= (op_ff == qlsf_pkg::OP_MUL);
               state_ff <= (op_ff == qlsf_pkg::OP_MUL) ? A_MUL : A_FPREP;
            end
            A_MUL: begin
               if (mb_ff == '0) begin
                  state_ff <= A_FSAT_SIGN;
               end else begin
                  if (mb_ff[0]) begin
                     acc_ff <= {1'b0, sum[qlsf_pkg::DW-1:0]};
                  end
                  ma_ff <= ma_ff << 1;
                  mb_ff <= mb_ff >> 1;
               end
            end
            A_FPREP: begin
               // num = 2*|a|*2^F + |b|, den = 2*|b|
               ma_ff    <= sum[qlsf_pkg::DW-1:0];
               mb_ff    <= mb_ff << 1;
               acc_ff   <= '0;
               cnt_ff   <= qlsf_pkg::CW'(qlsf_pkg::DW - 1);
               state_ff <= A_DIV;
            end
            A_DIV: begin
               acc_ff <= sum[qlsf_pkg::AW-1] ? rem_sh : sum[qlsf_pkg::DW:0];
               q_ff   <= {q_ff[qlsf_pkg::DW-2:0], ~sum[qlsf_pkg::AW-1]};
               ma_ff  <= ma_ff << 1;
               if (cnt_ff == '0) begin
                  state_ff <= A_FSAT_SIGN;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            A_FSAT_SIGN: begin
               if (!sign_ff) begin
                  acc_ff  <= {{(qlsf_pkg::DW + 1 - qlsf_pkg::OUT_W){1'b0}}, sat};
                  sign_ff <= 1'b1;
               end else begin
                  result_ff <= sum[qlsf_pkg::DW-1:0];
                  done_ff   <= 1'b1;
                  state_ff  <= A_IDLE;
               end
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

// ===== src/quadratic_least_squares_fit.sv =====
// Top level of the quadratic least-squares fit: sequencer, scratch RAM and
// shared arithmetic unit. Depends on qlsf_pkg, qlsf_ram and qlsf_alu.
//
// Usage: drive req_x_value, req_y_value and req_last_sample with start high;
// the transaction is taken at a clock edge where start is high and busy low.
// Each sample is folded into exact running sums of n, x, x^2, x^3, x^4, y,
// x*y and x^2*y by a microcoded sequence on one shift-add multiplier; busy
// stays high until the sequence ends, longer for a wider |x|, since each of
// the five multiplies loops once per bit of |x|.
// A sample flagged last also triggers the solve: Cramer's rule on the 3x3
// normal equations, 24 multiplies plus three 192-step restoring divides.
// A singular set skips the last nine multiplies and the divides. The sums
// are cleared before the result; one result transaction then appears for a
// single cycle with rsp_valid high, in the first cycle with busy low; the
// receiver cannot stall it. Samples beyond MAX_SAMPLES are dropped and
// reported as overflow unless the set is singular; a zero pivot reports
// singular with zero coefficients.
// Reset is synchronous; after it the block runs the same clearing pass over
// the sums in RAM before it takes the first sample.
`timescale 1ns / 1ps

module quadratic_least_squares_fit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [qlsf_pkg::X_W-1:0]    req_x_value,
   input  logic signed [qlsf_pkg::Y_W-1:0]    req_y_value,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   output logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_quad,
   output logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_lin,
   output logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_const,
   output logic [1:0]                         rsp_fit_status,
   output logic [qlsf_pkg::CNT_W-1:0]         rsp_samples_used
);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT} state_type;

   state_type                        state_ff;
   logic [qlsf_pkg::PC_W-1:0]        pc_ff;
   logic [qlsf_pkg::X_W-1:0]         x_ff;
   logic [qlsf_pkg::Y_W-1:0]         y_ff;
   logic                             last_ff;
   logic                             fit_ff;
   logic                             sing_ff;
   logic                             ovf_ff;
   logic [qlsf_pkg::CNT_W-1:0]       count_ff;
   logic [qlsf_pkg::OUT_W-1:0]       quad_ff;
   logic [qlsf_pkg::OUT_W-1:0]       lin_ff;
   logic [qlsf_pkg::OUT_W-1:0]       const_ff;
   logic                             rsp_valid_ff;
   logic [1:0]                       status_ff;
   logic [qlsf_pkg::CNT_W-1:0]       used_ff;

   qlsf_pkg::instr_type              instr;
   qlsf_pkg::alu_req_type            alu_req;
   qlsf_pkg::alu_rsp_type            alu_rsp;
   logic                             wr_en;
   logic [qlsf_pkg::DW-1:0]          wr_data;
   logic [qlsf_pkg::DW-1:0]          rd_a;
   logic [qlsf_pkg::DW-1:0]          rd_b;
   logic                             accept;

   assign instr  = qlsf_pkg::rom_fetch(pc_ff);
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   qlsf_ram #(
      .WIDTH (qlsf_pkg::DW),
      .DEPTH (qlsf_pkg::DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (instr.dst),
      .wr_data   (wr_data),
      .rd_addr_a (instr.a),
      .rd_addr_b (instr.b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   qlsf_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opnd_a (rd_a),
      .opnd_b (rd_b),
      .rsp    (alu_rsp)
   );

   always_comb begin
      wr_en         = 1'b0;
      wr_data       = '0;
      alu_req.start = 1'b0;
      alu_req.op    = instr.op;
      if (state_ff == S_EXEC) begin
         case (instr.op) inside
            qlsf_pkg::OP_LDX: begin
               wr_en   = 1'b1;
               wr_data = {{(qlsf_pkg::DW - qlsf_pkg::X_W){x_ff[qlsf_pkg::X_W-1]}}, x_ff};
            end
            qlsf_pkg::OP_LDY: begin
               wr_en   = 1'b1;
               wr_data = {{(qlsf_pkg::DW - qlsf_pkg::Y_W){y_ff[qlsf_pkg::Y_W-1]}}, y_ff};
            end
            qlsf_pkg::OP_LDN: begin
               wr_en   = 1'b1;
               wr_data = {{(qlsf_pkg::DW - qlsf_pkg::CNT_W){1'b0}}, count_ff};
            end
            qlsf_pkg::OP_CLR: begin
               wr_en = 1'b1;
            end
            qlsf_pkg::OP_ADD, qlsf_pkg::OP_SUB, qlsf_pkg::OP_MUL, qlsf_pkg::OP_FIX: begin
               alu_req.start = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end else if (state_ff == S_WAIT && alu_rsp.done && instr.op != qlsf_pkg::OP_FIX) begin
         wr_en   = 1'b1;
         wr_data = alu_rsp.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FETCH;
         pc_ff        <= qlsf_pkg::CLEAR_PC;
         fit_ff       <= 1'b0;
         sing_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  x_ff    <= req_x_value;
                  y_ff    <= req_y_value;
                  last_ff <= req_last_sample;
                  if (count_ff < qlsf_pkg::CNT_W'(qlsf_pkg::MAX_SAMPLES)) begin
                     count_ff <= count_ff + 1'b1;
                     pc_ff    <= qlsf_pkg::SAMPLE_PC;
                     state_ff <= S_FETCH;
                  end else begin
                     // sample dropped; a last one still runs the solve
                     ovf_ff <= 1'b1;
                     if (req_last_sample) begin
                        fit_ff   <= 1'b1;
                        pc_ff    <= qlsf_pkg::SOLVE_PC;
                        state_ff <= S_FETCH;
                     end
                  end
               end
            end
            S_FETCH: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               case (instr.op) inside
                  qlsf_pkg::OP_ADD, qlsf_pkg::OP_SUB, qlsf_pkg::OP_MUL, qlsf_pkg::OP_FIX: begin
                     state_ff <= S_WAIT;
                  end
                  qlsf_pkg::OP_LDN: begin
                     sing_ff  <= 1'b0;
                     quad_ff  <= '0;
                     lin_ff   <= '0;
                     const_ff <= '0;
                     pc_ff    <= pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
                  qlsf_pkg::OP_CHKZ: begin
                     if (rd_a == '0) begin
                        sing_ff <= 1'b1;
                     end
                     pc_ff    <= pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
                  qlsf_pkg::OP_BRSING: begin
                     pc_ff    <= sing_ff ? qlsf_pkg::CLEAR_PC : pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
                  qlsf_pkg::OP_ENDS: begin
                     if (last_ff) begin
                        fit_ff   <= 1'b1;
                        pc_ff    <= qlsf_pkg::SOLVE_PC;
                        state_ff <= S_FETCH;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
                  qlsf_pkg::OP_DONE: begin
                     if (fit_ff) begin
                        rsp_valid_ff <= 1'b1;
                        used_ff      <= count_ff;
                        status_ff    <= sing_ff ? qlsf_pkg::ST_SINGULAR :
                                        ovf_ff  ? qlsf_pkg::ST_OVERFLOW : qlsf_pkg::ST_OK;
                     end
                     fit_ff   <= 1'b0;
                     ovf_ff   <= 1'b0;
                     count_ff <= '0;
                     state_ff <= S_IDLE;
                  end
                  default: begin
                     pc_ff    <= pc_ff + 1'b1;
                     state_ff <= S_FETCH;
                  end
               endcase
            end
            S_WAIT: begin
               if (alu_rsp.done) begin
                  if (instr.op == qlsf_pkg::OP_FIX) begin
                     if (instr.dst == qlsf_pkg::OUT_QUAD) begin
                        quad_ff <= alu_rsp.result[qlsf_pkg::OUT_W-1:0];
                     end else if (instr.dst == qlsf_pkg::OUT_LIN) begin
                        lin_ff <= alu_rsp.result[qlsf_pkg::OUT_W-1:0];
                     end else begin
                        const_ff <= alu_rsp.result[qlsf_pkg::OUT_W-1:0];
                     end
                  end
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= S_FETCH;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coeff_quad   = quad_ff;
   assign rsp_coeff_lin    = lin_ff;
   assign rsp_coeff_const  = const_ff;
   assign rsp_fit_status   = status_ff;
   assign rsp_samples_used = used_ff;

   // a result only leaves once the sequencer has finished
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status == qlsf_pkg::ST_SINGULAR |->
         rsp_coeff_quad == '0 && rsp_coeff_lin == '0 && rsp_coeff_const == '0)
      else $error("singular fit with nonzero coefficients");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= qlsf_pkg::CNT_W'(qlsf_pkg::MAX_SAMPLES))
      else $error("sample count beyond limit");

endmodule

// ===== tb/qlsf_fit_checker.sv =====
// Checker for the quadratic fit: watches the sample and result channels,
// keeps its own exact sums and solve, and compares every result.
// Depends on qlsf_pkg for port widths and status codes.
`timescale 1ns / 1ps

module qlsf_fit_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic signed [qlsf_pkg::X_W-1:0]    req_x_value,
   input  logic signed [qlsf_pkg::Y_W-1:0]    req_y_value,
   input  logic                               req_last_sample,
   input  logic                               rsp_valid,
   input  logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_quad,
   input  logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_lin,
   input  logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_const,
   input  logic [1:0]                         rsp_fit_status,
   input  logic [qlsf_pkg::CNT_W-1:0]         rsp_samples_used,
   output int                                 fail_count,
   output int                                 fits_pending
);

   typedef logic signed [255:0] big_type;

   typedef struct {
      logic [qlsf_pkg::OUT_W-1:0] quad;
      logic [qlsf_pkg::OUT_W-1:0] lin;
      logic [qlsf_pkg::OUT_W-1:0] cnst;
      logic [1:0]                 status;
      logic [qlsf_pkg::CNT_W-1:0] used;
   } fit_type;

   fit_type fit_queue[$];
   longint  sum_n, sum_x, sum_x2, sum_x3, sum_x4, sum_y, sum_xy, sum_x2y;
   bit      dropped;

   assign fits_pending = fit_queue.size();

   function automatic big_type det3(big_type m00, big_type m01, big_type m02,
                                    big_type m10, big_type m11, big_type m12,
                                    big_type m20, big_type m21, big_type m22);
      return m00 * (m11 * m22 - m12 * m21) - m01 * (m10 * m22 - m12 * m20)
           + m02 * (m10 * m21 - m11 * m20);
   endfunction

   // round num/den to Q.16, ties away from zero, saturate to 48 bits
   function automatic logic [qlsf_pkg::OUT_W-1:0] to_q16(big_type num, big_type den);
      big_type     mn, md, q;
      logic [63:0] mag;
      bit          neg;
      neg = (num < 0) != (den < 0);
      mn  = (num < 0) ? -num : num;
      md  = (den < 0) ? -den : den;
      q   = ((mn <<< (qlsf_pkg::FRAC_BITS + 1)) + md) / (md <<< 1);
      mag = (q[255:48] != 0) ? 64'(qlsf_pkg::NEG_LIM) : 64'(q[47:0]);
      if (!neg && mag > 64'(qlsf_pkg::POS_LIM)) mag = 64'(qlsf_pkg::POS_LIM);
      if (neg && mag > 64'(qlsf_pkg::NEG_LIM)) mag = 64'(qlsf_pkg::NEG_LIM);
      mag = neg ? -mag : mag;
      return mag[qlsf_pkg::OUT_W-1:0];
   endfunction

   task automatic clear_sums();
      sum_n = 0; sum_x = 0; sum_x2 = 0; sum_x3 = 0; sum_x4 = 0;
      sum_y = 0; sum_xy = 0; sum_x2y = 0; dropped = 0;
   endtask

   task automatic fold_sample(longint xv, longint yv, logic last);
      big_type n, s1, s2, s3, s4, t0, t1, t2, p2, d;
      fit_type f;
      if (sum_n < qlsf_pkg::MAX_SAMPLES) begin
         sum_n++;
         sum_x   += xv;
         sum_x2  += xv * xv;
         sum_x3  += xv * xv * xv;
         sum_x4  += xv * xv * xv * xv;
         sum_y   += yv;
         sum_xy  += xv * yv;
         sum_x2y += xv * xv * yv;
      end else begin
         dropped = 1;
      end
      if (!last) return;
      n = sum_n; s1 = sum_x; s2 = sum_x2; s3 = sum_x3; s4 = sum_x4;
      t0 = sum_y; t1 = sum_xy; t2 = sum_x2y;
      p2 = s4 * s2 - s3 * s3;
      d  = det3(s4, s3, s2, s3, s2, s1, s2, s1, n);
      f.quad = '0; f.lin = '0; f.cnst = '0;
      if (s4 == 0 || p2 == 0 || d == 0) begin
         f.status = qlsf_pkg::ST_SINGULAR;
      end else begin
         f.quad   = to_q16(det3(t2, s3, s2, t1, s2, s1, t0, s1, n), d);
         f.lin    = to_q16(det3(s4, t2, s2, s3, t1, s1, s2, t0, n), d);
         f.cnst   = to_q16(det3(s4, s3, t2, s3, s2, t1, s2, s1, t0), d);
         f.status = dropped ? qlsf_pkg::ST_OVERFLOW : qlsf_pkg::ST_OK;
      end
      f.used = qlsf_pkg::CNT_W'(sum_n);
      fit_queue.push_back(f);
      clear_sums();
   endtask

   always @(posedge clock) begin
      fit_type f;
      if (reset) begin
         fail_count = 0;
         fit_queue.delete();
         clear_sums();
      end else begin
         if (rsp_valid) begin
            if (fit_queue.size() == 0) begin
               $error("unexpected result transaction");
               fail_count++;
            end else begin
               f = fit_queue.pop_front();
               if (rsp_coeff_quad !== f.quad) begin
                  $error("coeff_quad: expected %0d, got %0d", $signed(f.quad), rsp_coeff_quad);
                  fail_count++;
               end
               if (rsp_coeff_lin !== f.lin) begin
                  $error("coeff_lin: expected %0d, got %0d", $signed(f.lin), rsp_coeff_lin);
                  fail_count++;
               end
               if (rsp_coeff_const !== f.cnst) begin
                  $error("coeff_const: expected %0d, got %0d", $signed(f.cnst),
                         rsp_coeff_const);
                  fail_count++;
               end
               if (rsp_fit_status !== f.status) begin
                  $error("fit_status: expected %0d, got %0d", f.status, rsp_fit_status);
                  fail_count++;
               end
               if (rsp_samples_used !== f.used) begin
                  $error("samples_used: expected %0d, got %0d", f.used, rsp_samples_used);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            fold_sample(longint'(req_x_value), longint'(req_y_value), req_last_sample);
      end
   end

endmodule

// ===== tb/quadratic_least_squares_fit_tb.sv =====
// Testbench top for quadratic_least_squares_fit: clock, reset, sample
// stimulus and verdict. Depends on qlsf_pkg and qlsf_fit_checker.
`timescale 1ns / 1ps

module quadratic_least_squares_fit_tb;

   logic                               clock = 0;
   logic                               reset = 1;
   logic                               start = 0;
   logic                               busy;
   logic signed [qlsf_pkg::X_W-1:0]    req_x_value = '0;
   logic signed [qlsf_pkg::Y_W-1:0]    req_y_value = '0;
   logic                               req_last_sample = 0;
   logic                               rsp_valid;
   logic signed [qlsf_pkg::OUT_W-1:0]  rsp_coeff_quad, rsp_coeff_lin, rsp_coeff_const;
   logic [1:0]                         rsp_fit_status;
   logic [qlsf_pkg::CNT_W-1:0]         rsp_samples_used;
   int                                 fail_count, fits_pending;
   int                                 sent;

   always #1 clock = ~clock;

   quadratic_least_squares_fit dut (.*);
   qlsf_fit_checker checker_i (.*);

   task automatic send_sample(int xv, int yv, bit last);
      int r, gap;
      req_x_value     <= qlsf_pkg::X_W'(xv);
      req_y_value     <= qlsf_pkg::Y_W'(yv);
      req_last_sample <= last;
      start           <= 1;
      do @(posedge clock); while (busy);
      sent++;
      r = $urandom_range(0, 9);
      gap = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_x(int mode, int fixed_x);
      case (mode)
         0: return $urandom_range(0, 4095) - 2048;
         1: return $urandom_range(0, 8) - 4;
         default: return fixed_x;
      endcase
   endfunction

   task automatic random_set(int len);
      int xmode, fixed_x, yv;
      xmode   = ($urandom_range(0, 9) < 6) ? 0 : ($urandom_range(0, 3) != 0 ? 1 : 2);
      fixed_x = $urandom_range(0, 4095) - 2048;
      for (int i = 0; i < len; i++) begin
         yv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) - 32
                                          : $urandom_range(0, 65535) - 32768;
         send_sample(pick_x(xmode, fixed_x), yv, i == len - 1);
      end
   endtask

   initial begin
      bit big_done;
      int r;
      sent = 0;
      big_done = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      // field extremes
      send_sample(-2048, -32768, 0);
      send_sample(2047, 32767, 0);
      send_sample(0, 0, 1);
      // lone sample: singular
      send_sample(5, 7, 1);
      // one repeated abscissa: second pivot zero
      send_sample(3, 1, 0);
      send_sample(3, 2, 0);
      send_sample(3, 3, 1);
      // all x zero: first pivot zero
      send_sample(0, 100, 0);
      send_sample(0, -100, 0);
      send_sample(0, 5, 1);
      // two distinct abscissas: third pivot zero
      send_sample(1, 4, 0);
      send_sample(-1, 9, 0);
      send_sample(1, -3, 0);
      send_sample(-1, 2, 1);
      // exact parabola y = x^2
      send_sample(1, 1, 0);
      send_sample(2, 4, 0);
      send_sample(3, 9, 1);
      // near-degenerate spread at the ends
      send_sample(2047, 32767, 0);
      send_sample(2046, -32768, 0);
      send_sample(-2048, 0, 1);
      while (sent < 1400) begin
         if (!big_done && sent > 300) begin
            // more than MAX_SAMPLES in one set: overflow status, or singular if x is fixed
            random_set(qlsf_pkg::MAX_SAMPLES + 2);
            big_done = 1;
         end else begin
            r = $urandom_range(0, 9);
            random_set(r == 0 ? $urandom_range(1, 2) :
                       r == 1 ? $urandom_range(20, 60) : $urandom_range(3, 8));
         end
      end
      start <= 0;
      // let the checker take the final transaction before waiting on it
      @(posedge clock);
      wait (fits_pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("quadratic_least_squares_fit_tb: PASS");
      else
         $display("quadratic_least_squares_fit_tb: FAIL");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("quadratic_least_squares_fit_tb: FAIL");
      $finish;
   end

endmodule
